/* hdl/bmm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_pkg
// Widths and limb counts shared by the Barrett modular multiplier.
// ----------------------------------------------------------------------------
package bmm_pkg;
  localparam int MODULUS_BITS = 81;
  localparam int LOW_W   = 64;
  localparam int HIGH_W  = MODULUS_BITS - LOW_W;
  localparam int MU_W    = MODULUS_BITS + 2;
  localparam int MU_HW   = MU_W - LOW_W;
  localparam int LIMB_W  = 32;
  localparam int NA      = (MODULUS_BITS + LIMB_W - 1) / LIMB_W;
  localparam int NM      = (MU_W + LIMB_W - 1) / LIMB_W;
  localparam int T_W     = 2 * MODULUS_BITS;
  localparam int NT      = (T_W + LIMB_W - 1) / LIMB_W;
  localparam int NH      = (NT + 1) / 2;
  localparam int R_W     = MODULUS_BITS + 2;
  localparam int NR      = (R_W + LIMB_W - 1) / LIMB_W;
  localparam int TM_W    = T_W + MU_W;
  localparam int IDX_W   = 2;
  localparam logic [IDX_W-1:0] REG_MODULUS_LOW  = 2'd0;
  localparam logic [IDX_W-1:0] REG_MODULUS_HIGH = 2'd1;
  localparam logic [IDX_W-1:0] REG_MU_LOW       = 2'd2;
  localparam logic [IDX_W-1:0] REG_MU_HIGH      = 2'd3;
endpackage

/* hdl/bmm_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_in_if / bmm_out_if
// Valid/ready channels for operands and results.
// ----------------------------------------------------------------------------
interface bmm_in_if import bmm_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [LOW_W-1:0]  a_low;
  logic [HIGH_W-1:0] a_high;
  logic [LOW_W-1:0]  b_low;
  logic [HIGH_W-1:0] b_high;
  modport source (output valid, a_low, a_high, b_low, b_high, input ready);
  modport sink   (input valid, a_low, a_high, b_low, b_high, output ready);
endinterface

interface bmm_out_if import bmm_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [LOW_W-1:0]  product_low;
  logic [HIGH_W-1:0] product_high;
  modport source (output valid, product_low, product_high, input ready);
  modport sink   (input valid, product_low, product_high, output ready);
endinterface

/* hdl/barrett_modular_multiplier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barrett_modular_multiplier
// Pipelined a*b mod p by Barrett reduction with a configured mu.
// Throughput: one transaction per cycle; the whole pipe holds when the output
// stage is full and not taken.
// Reset: synchronous; clears valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module barrett_modular_multiplier import bmm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              write_enable,
  input  logic [IDX_W-1:0]  write_index,
  input  logic [LOW_W-1:0]  write_data,
  bmm_in_if.sink            in,
  bmm_out_if.source         out
);
  localparam int NS  = 13;
  localparam int R1W = LIMB_W * (NA + 1);
  localparam int R2W = LIMB_W * (NM + 1);
  localparam int PW  = LIMB_W * (NM + 2);
  localparam int R3W = LIMB_W * (NA + 1);

  logic [LOW_W-1:0]  modulus_low;
  logic [HIGH_W-1:0] modulus_high;
  logic [LOW_W-1:0]  mu_low;
  logic [MU_HW-1:0]  mu_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_low  <= '0;
      modulus_high <= HIGH_W'(1) << (HIGH_W - 1);
      mu_low       <= '0;
      mu_high      <= MU_HW'(1) << (MU_HW - 1);
    end else if (write_enable) begin
      case (write_index)
        REG_MODULUS_LOW:  modulus_low  <= write_data;
        REG_MODULUS_HIGH: modulus_high <= write_data[HIGH_W-1:0];
        REG_MU_LOW:       mu_low       <= write_data;
        REG_MU_HIGH:      mu_high      <= write_data[MU_HW-1:0];
        default: ;
      endcase
    end
  end

  logic [NA*LIMB_W-1:0] p_pad;
  logic [NM*LIMB_W-1:0] mu_pad;
  logic [R_W-1:0]       p_ext;
  assign p_pad  = (NA*LIMB_W)'({modulus_high, modulus_low});
  assign mu_pad = (NM*LIMB_W)'({mu_high, mu_low});
  assign p_ext  = R_W'({modulus_high, modulus_low});

  logic [NS-1:0] v;
  logic          en;
  assign en       = !v[NS-1] || out.ready;
  assign in.ready = en;
  assign out.valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NS-2:0], in.valid};
    end
  end

  // stage registers
  logic [NA*LIMB_W-1:0] s1_a, s1_b;
  logic [2*LIMB_W-1:0]  s2_pp [NA][NA];
  logic [R1W-1:0]       s3_row [NA];
  logic [NT*LIMB_W-1:0] s4_t;
  logic [2*LIMB_W-1:0]  s5_pp [NT][NM];
  logic [R_W-1:0]       s5_t, s6_t, s7_t, s8_t, s9_t, s10_t;
  logic [R2W-1:0]       s6_row [NT];
  logic [PW-1:0]        s7_pair [NH];
  logic [NR*LIMB_W-1:0] s8_q;
  logic [2*LIMB_W-1:0]  s9_pp [NR][NA];
  logic [R3W-1:0]       s10_row [NR];
  logic [R_W-1:0]       s11_r, s12_r, s13_r;

  logic [R1W-1:0]       row1_next [NA];
  logic [T_W-1:0]       t_next;
  logic [R2W-1:0]       row2_next [NT];
  logic [PW-1:0]        pair_next [NH];
  logic [TM_W-1:0]      tm_next;
  logic [R3W-1:0]       row3_next [NR];
  logic [R_W-1:0]       qp_next, r_next, r1_next, r2_next;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row1_next[i] = '0;
      for (int j = 0; j < NA; j++)
        row1_next[i] = row1_next[i] + (R1W'(s2_pp[i][j]) << (LIMB_W * j));
    end
    t_next = '0;
    for (int i = 0; i < NA; i++)
      t_next = t_next + (T_W'(s3_row[i]) << (LIMB_W * i));
    for (int i = 0; i < NT; i++) begin
      row2_next[i] = '0;
      for (int j = 0; j < NM; j++)
        row2_next[i] = row2_next[i] + (R2W'(s5_pp[i][j]) << (LIMB_W * j));
    end
    for (int h = 0; h < NH; h++) begin
      pair_next[h] = PW'(s6_row[2*h]);
      if (2*h + 1 < NT)
        pair_next[h] = pair_next[h] + (PW'(s6_row[2*h+1]) << LIMB_W);
    end
    tm_next = '0;
    for (int h = 0; h < NH; h++)
      tm_next = tm_next + (TM_W'(s7_pair[h]) << (2 * LIMB_W * h));
    for (int i = 0; i < NR; i++) begin
      row3_next[i] = '0;
      for (int j = 0; j < NA; j++)
        row3_next[i] = row3_next[i] + (R3W'(s9_pp[i][j]) << (LIMB_W * j));
    end
    qp_next = '0;
    for (int i = 0; i < NR; i++)
      qp_next = qp_next + R_W'(R_W'(s10_row[i]) << (LIMB_W * i));
    r_next  = s10_t - qp_next;
    r1_next = (s11_r >= p_ext) ? s11_r - p_ext : s11_r;
    r2_next = (s12_r >= p_ext) ? s12_r - p_ext : s12_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a <= (NA*LIMB_W)'({in.a_high, in.a_low});
      s1_b <= (NA*LIMB_W)'({in.b_high, in.b_low});
      for (int i = 0; i < NA; i++)
        for (int j = 0; j < NA; j++)
          s2_pp[i][j] <= s1_a[LIMB_W*i +: LIMB_W] * s1_b[LIMB_W*j +: LIMB_W];
      s3_row <= row1_next;
      s4_t   <= (NT*LIMB_W)'(t_next);
      for (int i = 0; i < NT; i++)
        for (int j = 0; j < NM; j++)
          s5_pp[i][j] <= s4_t[LIMB_W*i +: LIMB_W] * mu_pad[LIMB_W*j +: LIMB_W];
      s5_t    <= s4_t[R_W-1:0];
      s6_row  <= row2_next;
      s6_t    <= s5_t;
      s7_pair <= pair_next;
      s7_t    <= s6_t;
      s8_q    <= (NR*LIMB_W)'(tm_next[T_W +: R_W]);
      s8_t    <= s7_t;
      for (int i = 0; i < NR; i++)
        for (int j = 0; j < NA; j++)
          s9_pp[i][j] <= s8_q[LIMB_W*i +: LIMB_W] * p_pad[LIMB_W*j +: LIMB_W];
      s9_t    <= s8_t;
      s10_row <= row3_next;
      s10_t   <= s9_t;
      s11_r   <= r_next;
      s12_r   <= r1_next;
      s13_r   <= r2_next;
    end
  end

  assign out.product_low  = s13_r[LOW_W-1:0];
  assign out.product_high = s13_r[MODULUS_BITS-1:LOW_W];
endmodule

/* verif/bmm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_checker
// Watches the operand, result and register-write ports of the Barrett
// multiplier, predicts each residue from its own copy of p and mu, and
// compares results in order against the predicted residues.
// ----------------------------------------------------------------------------
module bmm_checker import bmm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             write_enable,
  input  logic [IDX_W-1:0] write_index,
  input  logic [LOW_W-1:0] write_data,
  bmm_in_if                in_ch,
  bmm_out_if               out_ch,
  output int               errors,
  output int               pending
);
  typedef struct packed {
    logic [LOW_W-1:0]  lo;
    logic [HIGH_W-1:0] hi;
  } residue_t;

  logic [LOW_W-1:0]  p_lo;
  logic [HIGH_W-1:0] p_hi;
  logic [LOW_W-1:0]  m_lo;
  logic [MU_HW-1:0]  m_hi;
  residue_t          expected_residues[$];

  function automatic residue_t reduce_product(logic [255:0] a, logic [255:0] b);
    logic [255:0] t, mu, p, q, r, tm;
    residue_t     res;
    p  = {p_hi, p_lo};
    mu = {m_hi, m_lo};
    t  = a * b;
    tm = t * mu;
    q  = tm >> T_W;
    r  = (t - q * p) & ((256'd1 << R_W) - 1);
    repeat (2) if (r >= p) r = r - p;
    res.lo = r[LOW_W-1:0];
    res.hi = r[MODULUS_BITS-1:LOW_W];
    return res;
  endfunction

  assign pending = expected_residues.size();

  always @(posedge clk) begin
    residue_t e;
    int       n;
    if (rst) begin
      p_lo <= '0;
      p_hi <= 17'h10000;
      m_lo <= '0;
      m_hi <= 19'h40000;
      errors <= 0;
      expected_residues.delete();
    end else begin
      n = 0;
      if (write_enable) begin
        case (write_index)
          REG_MODULUS_LOW:  p_lo <= write_data;
          REG_MODULUS_HIGH: p_hi <= write_data[HIGH_W-1:0];
          REG_MU_LOW:       m_lo <= write_data;
          REG_MU_HIGH:      m_hi <= write_data[MU_HW-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_residues.push_back(reduce_product({in_ch.a_high, in_ch.a_low},
                                                   {in_ch.b_high, in_ch.b_low}));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_residues.size() == 0) begin
          $error("unexpected result transaction");
          n = n + 1;
        end else begin
          e = expected_residues.pop_front();
          if (out_ch.product_low !== e.lo) begin
            $error("product_low: expected %h, got %h", e.lo, out_ch.product_low);
            n = n + 1;
          end
          if (out_ch.product_high !== e.hi) begin
            $error("product_high: expected %h, got %h", e.hi, out_ch.product_high);
            n = n + 1;
          end
        end
      end
      if (n != 0)
        errors <= errors + n;
    end
  end
endmodule

/* verif/barrett_modular_multiplier_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barrett_modular_multiplier_test
// Drives operands and register writes into the Barrett multiplier under
// several moduli (extremes, random, malformed and zero) and idle/stall mixes;
// the checker predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module barrett_modular_multiplier_test;
  import bmm_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             write_enable = 1'b0;
  logic [IDX_W-1:0] write_index = '0;
  logic [LOW_W-1:0] write_data = '0;
  int               errors, pending;
  int               idle_pct = 0, stall_pct = 0;
  int               quiet_cycles = 0;
  logic [255:0]     p_cur;

  bmm_in_if  in_ch();
  bmm_out_if out_ch();

  barrett_modular_multiplier i_dut (
    .clk(clk), .rst(rst), .write_enable(write_enable), .write_index(write_index),
    .write_data(write_data), .in(in_ch.sink), .out(out_ch.source)
  );

  bmm_checker i_checker (
    .clk(clk), .rst(rst), .write_enable(write_enable), .write_index(write_index),
    .write_data(write_data), .in_ch(in_ch), .out_ch(out_ch),
    .errors(errors), .pending(pending)
  );

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.a_low = '0; in_ch.a_high = '0; in_ch.b_low = '0; in_ch.b_high = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk)
    out_ch.ready <= !rst && ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [LOW_W-1:0] data);
    @(negedge clk);
    write_enable = 1'b1; write_index = idx; write_data = data;
    @(negedge clk);
    write_enable = 1'b0;
  endtask

  task automatic load_modulus(logic [255:0] p, logic [255:0] mu);
    p_cur = p;
    write_reg(REG_MODULUS_LOW, p[63:0]);
    write_reg(REG_MODULUS_HIGH, 64'(p[80:64]));
    write_reg(REG_MU_LOW, mu[63:0]);
    write_reg(REG_MU_HIGH, 64'(mu[82:64]));
  endtask

  task automatic multiply(logic [80:0] a, logic [80:0] b);
    @(negedge clk);
    in_ch.a_low = a[63:0]; in_ch.a_high = a[80:64];
    in_ch.b_low = b[63:0]; in_ch.b_high = b[80:64];
    in_ch.valid = ($urandom_range(99) >= idle_pct);
    forever begin
      @(posedge clk);
      if (in_ch.valid && in_ch.ready) break;
      @(negedge clk);
      if (!in_ch.valid) in_ch.valid = ($urandom_range(99) >= idle_pct);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [80:0] random_operand();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return p_cur[80:0] - 81'd1;
      default: return {17'($urandom), $urandom, $urandom};
    endcase
  endfunction

  initial begin
    logic [255:0] p, mu;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: largest modulus, operand extremes
    p = (256'd1 << 81) - 1;
    load_modulus(p, (256'd1 << 162) / p);
    multiply('0, '0);
    multiply('1, '1);
    multiply('0, '1);
    multiply(81'd1, '1);
    multiply(p[80:0] - 1, p[80:0] - 1);
    multiply(p[80:0], 81'd1);
    multiply({17'h1ffff, 64'd0}, {17'd0, 64'hffffffffffffffff});
    multiply({17'd0, 64'hffffffffffffffff}, {17'h1ffff, 64'd0});
    multiply({17'h0aaaa, 64'h5555555555555555}, {17'h15555, 64'haaaaaaaaaaaaaaaa});
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      case (ph % 5)
        0: p = 256'd1 << 80;
        1: p = (256'd1 << 81) - 1;
        2: p = {1'b1, 16'($urandom), $urandom, $urandom};
        default: p = {1'b0, 16'($urandom), $urandom, $urandom};
      endcase
      if (ph % 5 == 4) p = '0;
      if (ph % 5 >= 3)
        mu = {$urandom_range(262144), $urandom, $urandom};
      else
        mu = (256'd1 << 162) / p;
      if (ph == 8) mu = {19'd262144, 64'hffffffffffffffff};
      load_modulus(p, mu);
      repeat (40) multiply(random_operand(), random_operand());
      drain();
    end

    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

/* files.f */
hdl/bmm_pkg.sv
hdl/bmm_if.sv
hdl/barrett_modular_multiplier.sv
verif/bmm_checker.sv
verif/barrett_modular_multiplier_test.sv
